>>> hw/rtl/icfr_pkg.sv
// Shared types for the intensity false-color ramp pipeline.
`timescale 1ns / 1ps
`default_nettype none

package icfr_pkg;

  // What a word becomes at the end of the pipe.
  typedef enum logic [1:0] {
    KIND_RAMP  = 2'd0,
    KIND_CYAN  = 2'd1,
    KIND_WHITE = 2'd2,
    KIND_BLACK = 2'd3
  } kind_t;

  // Per-word control that travels with the datapath between modules.
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } tag_t;

endpackage

`default_nettype wire

>>> hw/rtl/intensity_false_color_ramp.sv
// Top level: pixel intensity to RGB false color, streaming in and out.
//
// Usage:
//   in_*   : one pixel word per handshake; tdata = intensity, tuser bit 0 = NaN,
//            bit 1 = Inf. NaN wins over Inf.
//   out_*  : one RGB word per pixel, in input order, tdata = red, green, blue.
//   cfg_*  : APB-style writes; 0x0 max_intensity, 0x4 curve_enable (bit 0).
//            Write only while the pipe is empty.
// Pipeline from input handshake to out_tvalid: classify stage, one divider
//   stage per ratio bit, curve index multiply, registered curve ROM read, ramp
//   multiply, output register.
// Throughput: one word per cycle while out_tready stays high, set by the one-bit-per-stage divider.
// Reset: all valid bits clear, config registers read zero (black for finite pixels).
// Stall: when out_tready is low, words pile up into empty stages (bubbles
//   collapse); in_tready drops only once every stage holds a word. Nothing
//   is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module intensity_false_color_ramp #(
  parameter int INTENSITY_BITS  = 16,
  parameter int RATIO_FRAC_BITS = 12,
  parameter int CURVE_ROM_DEPTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: intensity
  input  wire logic [((INTENSITY_BITS+7)/8)*8-1:0] in_tdata,
  // in_tuser: is_nan, is_inf
  input  wire logic [1:0]             in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // out_tdata: red, green, blue
  output logic      [23:0]            out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [2:0]             cfg_paddr,
  input  wire logic [31:0]            cfg_pwdata,
  output logic      [31:0]            cfg_prdata,
  output logic                        cfg_pready
);
  import icfr_pkg::*;

  localparam int IB = INTENSITY_BITS;
  localparam int F  = RATIO_FRAC_BITS;

  logic [IB-1:0] max_intensity;
  logic          curve_en;

  // divider -> curve
  tag_t          div_tag;
  logic [F-1:0]  div_quot;
  logic          div_sat;
  logic          curve_ready;

  // curve -> ramp
  tag_t          crv_tag;
  logic [F:0]    crv_ratio;
  logic          ramp_ready;

  logic [7:0]    red, green, blue;

  icfr_cfg #(
    .INTENSITY_BITS (IB)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .max_intensity (max_intensity),
    .curve_en      (curve_en)
  );

  // classify + ratio = intensity * 2^F / max, one bit per stage
  icfr_div #(
    .INTENSITY_BITS  (IB),
    .RATIO_FRAC_BITS (F)
  ) u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_intensity  (in_tdata[IB-1:0]),
    .in_is_nan     (in_tuser[0]),
    .in_is_inf     (in_tuser[1]),
    .max_intensity (max_intensity),
    .out_tag       (div_tag),
    .out_quot      (div_quot),
    .out_sat       (div_sat),
    .out_ready     (curve_ready)
  );

  // saturate at one, optional power-0.6 bend through the ROM
  icfr_curve #(
    .RATIO_FRAC_BITS (F),
    .CURVE_ROM_DEPTH (CURVE_ROM_DEPTH)
  ) u_curve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tag    (div_tag),
    .in_ready  (curve_ready),
    .in_quot   (div_quot),
    .in_sat    (div_sat),
    .curve_en  (curve_en),
    .out_tag   (crv_tag),
    .out_ratio (crv_ratio),
    .out_ready (ramp_ready)
  );

  // four quarter segments, special colors, output register
  icfr_ramp #(
    .RATIO_FRAC_BITS (F)
  ) u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tag    (crv_tag),
    .in_ready  (ramp_ready),
    .in_ratio  (crv_ratio),
    .out_valid (out_tvalid),
    .out_red   (red),
    .out_green (green),
    .out_blue  (blue),
    .out_ready (out_tready)
  );

  assign out_tdata = {blue, green, red};

endmodule

`default_nettype wire

>>> hw/rtl/icfr_cfg.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module icfr_cfg #(
  parameter int INTENSITY_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [2:0]                cfg_paddr,
  input  wire logic [31:0]               cfg_pwdata,
  output logic      [31:0]               cfg_prdata,
  output logic                           cfg_pready,
  output logic      [INTENSITY_BITS-1:0] max_intensity,
  output logic                           curve_en
);

  localparam logic REG_MAX   = 1'b0;
  localparam logic REG_CURVE = 1'b1;

  logic [INTENSITY_BITS-1:0] max_r;
  logic                      curve_r;
  logic                      wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= '0;
      curve_r <= 1'b0;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_MAX:   max_r   <= cfg_pwdata[INTENSITY_BITS-1:0];
        REG_CURVE: curve_r <= cfg_pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAX:   cfg_prdata = 32'(max_r);
      REG_CURVE: cfg_prdata = {31'd0, curve_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign max_intensity = max_r;
  assign curve_en      = curve_r;

endmodule

`default_nettype wire

>>> hw/rtl/icfr_div.sv
// Classify stage and pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module icfr_div #(
  parameter int INTENSITY_BITS  = 16,
  parameter int RATIO_FRAC_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [INTENSITY_BITS-1:0]  in_intensity,
  input  wire logic                       in_is_nan,
  input  wire logic                       in_is_inf,
  input  wire logic [INTENSITY_BITS-1:0]  max_intensity,
  output icfr_pkg::tag_t                  out_tag,
  output logic      [RATIO_FRAC_BITS-1:0] out_quot,
  output logic                            out_sat,
  input  wire logic                       out_ready
);
  import icfr_pkg::*;

  localparam int IB = INTENSITY_BITS;
  localparam int F  = RATIO_FRAC_BITS;

  // index 0 is the classify stage, 1..F are the divide steps
  logic          v_r    [F+1];
  kind_t         kind_r [F+1];
  logic          sat_r  [F+1];
  logic [IB-1:0] rem_r  [F+1];
  logic [F-1:0]  quot_r [F+1];
  logic          rdy    [F+1];

  kind_t kind_nxt;

  for (genvar k = 0; k < F; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign rdy[F]   = !v_r[F] || out_ready;
  assign in_ready = rdy[0];

  always_comb begin
    priority if (in_is_nan)         kind_nxt = KIND_CYAN;
    else if (in_is_inf)             kind_nxt = KIND_WHITE;
    else if (max_intensity == '0)   kind_nxt = KIND_BLACK;
    else                            kind_nxt = KIND_RAMP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
    if (rdy[0]) begin
      kind_r[0] <= kind_nxt;
      // at or above the maximum the ratio pins to one
      sat_r[0]  <= (in_intensity >= max_intensity);
      rem_r[0]  <= in_intensity;
      quot_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_step
    logic [IB:0]   sh;
    logic          ge;
    logic [IB-1:0] rem_nxt;

    always_comb begin
      sh      = {rem_r[k-1], 1'b0};
      ge      = (sh >= {1'b0, max_intensity});
      rem_nxt = ge ? IB'(sh - {1'b0, max_intensity}) : sh[IB-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_r[k-1];
      end
      if (rdy[k]) begin
        kind_r[k] <= kind_r[k-1];
        sat_r[k]  <= sat_r[k-1];
        rem_r[k]  <= rem_nxt;
        quot_r[k] <= {quot_r[k-1][F-2:0], ge};
      end
    end
  end

  assign out_tag.valid = v_r[F];
  assign out_tag.kind  = kind_r[F];
  assign out_quot      = quot_r[F];
  assign out_sat       = sat_r[F];

endmodule

`default_nettype wire

>>> hw/rtl/icfr_curve.sv
// Ratio saturation, curve ROM index and registered power-0.6 ROM lookup.
`timescale 1ns / 1ps
`default_nettype none

module icfr_curve #(
  parameter int RATIO_FRAC_BITS = 12,
  parameter int CURVE_ROM_DEPTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire icfr_pkg::tag_t             in_tag,
  output logic                            in_ready,
  input  wire logic [RATIO_FRAC_BITS-1:0] in_quot,
  input  wire logic                       in_sat,
  input  wire logic                       curve_en,
  output icfr_pkg::tag_t                  out_tag,
  output logic      [RATIO_FRAC_BITS:0]   out_ratio,
  input  wire logic                       out_ready
);
  import icfr_pkg::*;

  localparam int F     = RATIO_FRAC_BITS;
  localparam int DEPTH = CURVE_ROM_DEPTH;
  localparam int IDXW  = $clog2(DEPTH + 1);
  localparam int PW    = F + IDXW + 1;
  localparam logic [F:0]    ONE     = (F+1)'(1) << F;
  localparam logic [PW-1:0] DEPTH_W = PW'(DEPTH);

  typedef logic [F:0] rom_t [DEPTH+1];

  // entry i: largest y <= ONE with (y/ONE)^5 <= (i/DEPTH)^3
  function automatic rom_t build_rom();
    rom_t         tbl;
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [127:0] d3;
    logic [127:0] yw;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  y;
    d3 = 128'(DEPTH) * 128'(DEPTH) * 128'(DEPTH);
    for (int i = 0; i <= DEPTH; i++) begin
      rhs = (128'(i) * 128'(i) * 128'(i)) << (5 * F);
      lo  = 0;
      hi  = 1 << F;
      while (lo < hi) begin
        y   = (lo + hi + 1) >> 1;
        yw  = 128'(y);
        lhs = yw * yw * yw * yw * yw * d3;
        if (lhs <= rhs) lo = y;
        else            hi = y - 1;
      end
      tbl[i] = (F+1)'(lo);
    end
    return tbl;
  endfunction

  localparam rom_t CURVE_ROM = build_rom();

  logic            vb_r, vc_r;
  kind_t           kindb_r, kindc_r;
  logic [F:0]      ratiob_r, ratioc_r;
  logic            useb_r;
  logic [IDXW-1:0] idxb_r;
  logic            rdy_b, rdy_c;

  logic [F:0]      ratio_nxt;
  logic [PW-1:0]   prod;

  assign rdy_c    = !vc_r || out_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign in_ready = rdy_b;

  always_comb begin
    ratio_nxt = in_sat ? ONE : {1'b0, in_quot};
    prod      = PW'(ratio_nxt) * DEPTH_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_b) vb_r <= in_tag.valid;
      if (rdy_c) vc_r <= vb_r;
    end
    if (rdy_b) begin
      kindb_r  <= in_tag.kind;
      ratiob_r <= ratio_nxt;
      useb_r   <= curve_en && (ratio_nxt != '0);
      idxb_r   <= prod[F+IDXW-1:F];
    end
    if (rdy_c) begin
      kindc_r  <= kindb_r;
      ratioc_r <= useb_r ? CURVE_ROM[idxb_r] : ratiob_r;
    end
  end

  assign out_tag.valid = vc_r;
  assign out_tag.kind  = kindc_r;
  assign out_ratio     = ratioc_r;

endmodule

`default_nettype wire

>>> hw/rtl/icfr_ramp.sv
// Quarter-segment color ramp, special colors and the output register.
`timescale 1ns / 1ps
`default_nettype none

module icfr_ramp #(
  parameter int RATIO_FRAC_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire icfr_pkg::tag_t           in_tag,
  output logic                          in_ready,
  input  wire logic [RATIO_FRAC_BITS:0] in_ratio,
  output logic                          out_valid,
  output logic      [7:0]               out_red,
  output logic      [7:0]               out_green,
  output logic      [7:0]               out_blue,
  input  wire logic                     out_ready
);
  import icfr_pkg::*;

  localparam int F  = RATIO_FRAC_BITS;
  localparam int NW = F + 9;
  localparam logic [F-2:0]  QUARTER = (F-1)'(1) << (F - 2);
  localparam logic [NW-1:0] SCALE   = NW'(255 * 4);
  localparam logic [7:0]    FULL    = 8'hFF;

  typedef enum logic [1:0] {
    SEG_RED_UP   = 2'd0,
    SEG_GREEN_UP = 2'd1,
    SEG_RED_DOWN = 2'd2,
    SEG_TOP      = 2'd3
  } seg_t;

  logic          vd_r, ve_r;
  kind_t         kindd_r;
  seg_t          segd_r;
  logic [NW-1:0] numd_r;
  logic [7:0]    red_r, green_r, blue_r;
  logic          rdy_d, rdy_e;

  logic [F-2:0]  d_nxt;
  seg_t          seg_nxt;
  logic [7:0]    flo;
  logic [8:0]    cei;
  logic [7:0]    red_nxt, green_nxt, blue_nxt;

  assign rdy_e    = !ve_r || out_ready;
  assign rdy_d    = !vd_r || rdy_e;
  assign in_ready = rdy_d;

  // ratio equal to one is the only value with the top bit set
  always_comb begin
    if (in_ratio[F]) begin
      seg_nxt = SEG_TOP;
      d_nxt   = QUARTER;
    end else begin
      seg_nxt = seg_t'(in_ratio[F-1:F-2]);
      d_nxt   = {1'b0, in_ratio[F-3:0]};
    end
  end

  always_comb begin
    flo = numd_r[F+7:F];
    cei = {1'b0, flo} + 9'(|numd_r[F-1:0]);
    unique case (kindd_r)
      KIND_CYAN: begin
        red_nxt = 8'h00; green_nxt = FULL; blue_nxt = FULL;
      end
      KIND_WHITE: begin
        red_nxt = FULL; green_nxt = FULL; blue_nxt = FULL;
      end
      KIND_BLACK: begin
        red_nxt = 8'h00; green_nxt = 8'h00; blue_nxt = 8'h00;
      end
      default: begin
        unique case (segd_r)
          SEG_RED_UP: begin
            red_nxt = flo; green_nxt = 8'h00; blue_nxt = 8'h00;
          end
          SEG_GREEN_UP: begin
            red_nxt = FULL; green_nxt = flo; blue_nxt = 8'h00;
          end
          SEG_RED_DOWN: begin
            red_nxt = 8'(9'(FULL) - cei); green_nxt = FULL; blue_nxt = flo;
          end
          default: begin
            red_nxt = flo; green_nxt = FULL; blue_nxt = FULL;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (rdy_d) vd_r <= in_tag.valid;
      if (rdy_e) ve_r <= vd_r;
    end
    if (rdy_d) begin
      kindd_r <= in_tag.kind;
      segd_r  <= seg_nxt;
      numd_r  <= NW'(d_nxt) * SCALE;
    end
    if (rdy_e) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = ve_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

`default_nettype wire
